// ===== hdl/psc_pkg.sv =====
// Package for the packet statistics counters: field widths, protocol codes,
// state machine types and the control structs of the shared divider.
// No dependencies; every other file of the block imports it.
package psc_pkg;

  // Widths of the transaction fields.
  localparam int unsigned LEN_W      = 16;
  localparam int unsigned PROTO_W    = 8;
  localparam int unsigned MS_W       = 32;
  localparam int unsigned CNT_OUT_W  = 32;
  localparam int unsigned BYTE_OUT_W = 48;
  localparam int unsigned PPS_W      = 40;
  localparam int unsigned BPS_W      = 62;
  localparam int unsigned MEAN_W     = 24;

  // The divider produces at most this many quotient bits.
  localparam int unsigned QUO_W  = 62;
  localparam int unsigned STEP_W = 6;

  // IP protocol numbers that get a counter of their own.
  localparam logic [PROTO_W-1:0] PROTO_TCP   = 8'd6;
  localparam logic [PROTO_W-1:0] PROTO_UDP   = 8'd17;
  localparam logic [PROTO_W-1:0] PROTO_ICMP  = 8'd1;
  localparam logic [PROTO_W-1:0] PROTO_ICMP6 = 8'd58;

  // Top-level sequencer.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_OUT
  } psc_state_t;

  // Which quotient the divider is working on.
  typedef enum logic [1:0] {
    OP_PPS,
    OP_BPS,
    OP_MEAN
  } psc_op_t;

  // Divider sequencer.
  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_CHECK,
    DIV_RUN,
    DIV_DONE
  } psc_div_state_t;

  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
  } psc_div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic sat;
  } psc_div_sts_t;

endpackage

// ===== hdl/psc_if.sv =====
// Channel interfaces of the packet statistics counters: the packet event
// channel and the result channel, each with valid/ready handshake.
// Depends on psc_pkg for the field widths.
interface psc_in_if import psc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [LEN_W-1:0]   packet_length;
  logic [PROTO_W-1:0] ip_proto;
  logic [MS_W-1:0]    elapsed_ms;

  modport source (output valid, packet_length, ip_proto, elapsed_ms, input ready);
  modport sink (input valid, packet_length, ip_proto, elapsed_ms, output ready);
endinterface

interface psc_out_if import psc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CNT_OUT_W-1:0]  pkt_count;
  logic [BYTE_OUT_W-1:0] byte_count;
  logic [CNT_OUT_W-1:0]  tcp_count;
  logic [CNT_OUT_W-1:0]  udp_count;
  logic [CNT_OUT_W-1:0]  icmp_count;
  logic [CNT_OUT_W-1:0]  misc_count;
  logic [PPS_W-1:0]      packets_per_second;
  logic [BPS_W-1:0]      bits_per_second;
  logic [MEAN_W-1:0]     mean_length;

  modport source (
    output valid, pkt_count, byte_count, tcp_count, udp_count, icmp_count,
           misc_count, packets_per_second, bits_per_second, mean_length,
    input  ready
  );
  modport sink (
    input  valid, pkt_count, byte_count, tcp_count, udp_count, icmp_count,
           misc_count, packets_per_second, bits_per_second, mean_length,
    output ready
  );
endinterface

// ===== hdl/psc_div.sv =====
// Radix-2 restoring divider shared by the three statistics quotients.
// Depends on psc_pkg for the control structs and the sequencer enum.
// The dividend high part, the divisor and the step count stay stable while busy.
module psc_div import psc_pkg::*; #(
  parameter int unsigned HI_W   = 90,
  parameter int unsigned DVSR_W = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  psc_div_ctl_t       ctl,
  input  logic [HI_W-1:0]    hi,
  input  logic [QUO_W-1:0]   lo,
  input  logic [DVSR_W-1:0]  divisor,
  output psc_div_sts_t       sts,
  output logic [QUO_W-1:0]   quotient
);

  localparam int unsigned CMP_W = (HI_W > DVSR_W) ? HI_W : DVSR_W;

  psc_div_state_t    state_r, state_nxt;
  logic [STEP_W-1:0] step_r;
  logic [DVSR_W-1:0] rem_r;
  logic [QUO_W-1:0]  lo_r;
  logic [QUO_W-1:0]  quo_r;
  logic              sat_r;

  logic              hi_ge;
  logic [DVSR_W:0]   partial;
  logic [DVSR_W+1:0] diff;
  logic              take;

  // The quotient fits in the requested width only if the high part is below the divisor.
  assign hi_ge = CMP_W'(hi) >= CMP_W'(divisor);

  // One restoring step: shift in the next dividend bit and try the subtraction.
  assign partial = {rem_r, lo_r[QUO_W-1]};
  assign diff    = {1'b0, partial} - {2'b00, divisor};
  assign take    = ~diff[DVSR_W+1];

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      DIV_IDLE: begin
        if (ctl.start) state_nxt = DIV_CHECK;
      end
      DIV_CHECK: begin
        state_nxt = hi_ge ? DIV_DONE : DIV_RUN;
      end
      DIV_RUN: begin
        if (step_r == STEP_W'(1)) state_nxt = DIV_DONE;
      end
      DIV_DONE: begin
        state_nxt = DIV_IDLE;
      end
      default: state_nxt = DIV_IDLE;
    endcase
  end

  // Status outputs.
  always_comb begin
    sts = '0;
    unique case (state_r)
      DIV_IDLE:  sts.busy = 1'b0;
      DIV_CHECK: sts.busy = 1'b1;
      DIV_RUN:   sts.busy = 1'b1;
      DIV_DONE: begin
        sts.busy = 1'b1;
        sts.done = 1'b1;
        sts.sat  = sat_r;
      end
      default: sts = '0;
    endcase
  end

  assign quotient = quo_r;

  // Sequencer state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= DIV_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state_r)
      DIV_IDLE: begin
        if (ctl.start) begin
          step_r <= ctl.steps;
          lo_r   <= lo;
          quo_r  <= '0;
        end
      end
      DIV_CHECK: begin
        sat_r <= hi_ge;
        rem_r <= hi[DVSR_W-1:0];
      end
      DIV_RUN: begin
        rem_r  <= take ? diff[DVSR_W-1:0] : partial[DVSR_W-1:0];
        lo_r   <= {lo_r[QUO_W-2:0], 1'b0};
        quo_r  <= {quo_r[QUO_W-2:0], take};
        step_r <= step_r - STEP_W'(1);
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== hdl/packet_statistics_counters.sv =====
// Top level of the packet statistics counters: counters, sequencer and result register.
// Depends on psc_pkg, the channel interfaces in psc_if and the divider psc_div.
//
// Usage:
// A packet event arrives on in_chan (length, protocol number, milliseconds since
// the counters were cleared). The block counts it into saturating packet, byte and
// per-protocol totals, then works out the packet rate, the bit rate and the mean
// length with one shared radix-2 divider, one quotient bit per cycle.
// Each event yields exactly one result transaction on out_chan carrying all counters,
// both rates and the mean length.
// Each quotient is worked out in turn: the sequencer loads the dividend and starts
// the divider, which checks the range and then runs one step per quotient bit
// (40, 62 and 24 bits); after the last quotient the result register is loaded. With zero
// elapsed_ms the rates are held and only the mean length is divided.
// A quotient that saturates skips its divider steps. in_chan.ready is high only
// while the sequencer is idle, so one event is in work at a time and a new event
// is taken only after the result of the last one has been loaded.
// The result sits in an output register; if the receiver stalls, the block still
// takes the next event and holds that event's result until the register frees.
// Synchronous reset clears all counters, the held rates and the output valid.
module packet_statistics_counters import psc_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = 32,
  parameter int unsigned BYTE_WIDTH  = 48,
  parameter int unsigned FRAC_BITS   = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  psc_in_if.sink    in_chan,
  psc_out_if.source out_chan
);

  // 1000 fits in 10 bits and 8000 in 13 bits.
  localparam int unsigned PR_W   = COUNT_WIDTH + 10 + FRAC_BITS;
  localparam int unsigned BR_W   = BYTE_WIDTH + 13;
  localparam int unsigned ML_W   = BYTE_WIDTH + FRAC_BITS;
  localparam int unsigned PM_W   = (PR_W > ML_W) ? PR_W : ML_W;
  localparam int unsigned PROD_W = (PM_W > BR_W) ? PM_W : BR_W;
  localparam int unsigned DVSR_W = (COUNT_WIDTH > MS_W) ? COUNT_WIDTH : MS_W;
  localparam int unsigned CNT_X_W  = (COUNT_WIDTH > CNT_OUT_W) ? COUNT_WIDTH : CNT_OUT_W;
  localparam int unsigned BYTE_X_W = (BYTE_WIDTH > BYTE_OUT_W) ? BYTE_WIDTH : BYTE_OUT_W;

  // Saturate a counter to the width of its output field.
  function automatic logic [CNT_OUT_W-1:0] clamp_cnt(input logic [COUNT_WIDTH-1:0] v);
    logic [CNT_X_W-1:0] ext;
    ext = CNT_X_W'(v);
    if (ext > CNT_X_W'({CNT_OUT_W{1'b1}})) return '1;
    return ext[CNT_OUT_W-1:0];
  endfunction

  function automatic logic [BYTE_OUT_W-1:0] clamp_bytes(input logic [BYTE_WIDTH-1:0] v);
    logic [BYTE_X_W-1:0] ext;
    ext = BYTE_X_W'(v);
    if (ext > BYTE_X_W'({BYTE_OUT_W{1'b1}})) return '1;
    return ext[BYTE_OUT_W-1:0];
  endfunction

  psc_state_t state_r, state_nxt;
  psc_op_t    op_r;

  logic [COUNT_WIDTH-1:0] packet_total_r, tcp_total_r, udp_total_r, icmp_total_r, other_total_r;
  logic [BYTE_WIDTH-1:0]  byte_total_r;
  logic [PPS_W-1:0]       held_packet_rate_r;
  logic [BPS_W-1:0]       held_bps_r;
  logic [MEAN_W-1:0]      held_mean_length_r;
  logic [MS_W-1:0]        ms_r;
  logic [PROD_W-1:0]      prod_r;

  logic                   out_valid_r;
  logic [CNT_OUT_W-1:0]   out_pkt_count_r, out_tcp_count_r, out_udp_count_r;
  logic [CNT_OUT_W-1:0]   out_icmp_count_r, out_misc_count_r;
  logic [BYTE_OUT_W-1:0]  out_byte_count_r;
  logic [PPS_W-1:0]       out_pps_r;
  logic [BPS_W-1:0]       out_bps_r;
  logic [MEAN_W-1:0]      out_mean_r;

  logic                   in_ready;
  logic                   in_accept;
  logic                   prod_load;
  logic                   div_capture;
  logic                   out_free;
  logic                   out_load;
  logic [BYTE_WIDTH:0]    byte_sum;
  logic [PROD_W-1:0]      pkt_ext, byte_ext, prod_nxt;
  logic [PROD_W-1:0]      div_hi;
  logic [QUO_W-1:0]       div_lo;
  logic [DVSR_W-1:0]      div_divisor;
  logic [QUO_W-1:0]       div_quotient;
  logic                   div_start;
  logic [STEP_W-1:0]      div_steps;
  psc_div_ctl_t           div_ctl;
  psc_div_sts_t           div_sts;

  assign in_accept = in_chan.valid && in_ready;
  assign out_free  = !out_valid_r || out_chan.ready;
  assign byte_sum  = {1'b0, byte_total_r} + (BYTE_WIDTH + 1)'(in_chan.packet_length);

  // Dividend: counter times the scale, built from shifts (1000 = 1024 - 16 - 8,
  // 8000 = 8192 - 128 - 64).
  assign pkt_ext  = PROD_W'(packet_total_r);
  assign byte_ext = PROD_W'(byte_total_r);
  always_comb begin
    case (op_r)
      OP_PPS:  prod_nxt = ((pkt_ext << 10) - (pkt_ext << 4) - (pkt_ext << 3)) << FRAC_BITS;
      OP_BPS:  prod_nxt = (byte_ext << 13) - (byte_ext << 7) - (byte_ext << 6);
      OP_MEAN: prod_nxt = byte_ext << FRAC_BITS;
      default: prod_nxt = '0;
    endcase
  end

  // Split the dividend at the quotient width: the high part must stay below the
  // divisor, the low part is shifted in one bit per step.
  always_comb begin
    div_steps   = STEP_W'(MEAN_W);
    div_hi      = prod_r >> MEAN_W;
    div_lo      = QUO_W'(prod_r) << (QUO_W - MEAN_W);
    div_divisor = DVSR_W'(packet_total_r);
    case (op_r)
      OP_PPS: begin
        div_steps   = STEP_W'(PPS_W);
        div_hi      = prod_r >> PPS_W;
        div_lo      = QUO_W'(prod_r) << (QUO_W - PPS_W);
        div_divisor = DVSR_W'(ms_r);
      end
      OP_BPS: begin
        div_steps   = STEP_W'(BPS_W);
        div_hi      = prod_r >> BPS_W;
        div_lo      = QUO_W'(prod_r);
        div_divisor = DVSR_W'(ms_r);
      end
      default: begin
      end
    endcase
  end

  assign div_ctl = '{start: div_start, steps: div_steps};

  psc_div #(
    .HI_W   (PROD_W),
    .DVSR_W (DVSR_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (div_ctl),
    .hi       (div_hi),
    .lo       (div_lo),
    .divisor  (div_divisor),
    .sts      (div_sts),
    .quotient (div_quotient)
  );

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_chan.valid) state_nxt = ST_MUL;
      end
      ST_MUL:       state_nxt = ST_DIV_START;
      ST_DIV_START: state_nxt = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (div_sts.done) state_nxt = (op_r == OP_MEAN) ? ST_OUT : ST_MUL;
      end
      ST_OUT: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ready    = 1'b0;
    prod_load   = 1'b0;
    div_start   = 1'b0;
    div_capture = 1'b0;
    out_load    = 1'b0;
    unique case (state_r)
      ST_IDLE:      in_ready = 1'b1;
      ST_MUL:       prod_load = 1'b1;
      ST_DIV_START: div_start = 1'b1;
      ST_DIV_WAIT:  div_capture = div_sts.done;
      ST_OUT:       out_load = out_free;
      default:      in_ready = 1'b0;
    endcase
  end

  assign in_chan.ready = in_ready;

  // Control state and counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r            <= ST_IDLE;
      op_r               <= OP_MEAN;
      packet_total_r     <= '0;
      byte_total_r       <= '0;
      tcp_total_r        <= '0;
      udp_total_r        <= '0;
      icmp_total_r       <= '0;
      other_total_r      <= '0;
      held_packet_rate_r <= '0;
      held_bps_r         <= '0;
      held_mean_length_r <= '0;
      out_valid_r        <= 1'b0;
    end else begin
      state_r <= state_nxt;

      // Count the event; every counter holds at all ones.
      if (in_accept) begin
        op_r <= (in_chan.elapsed_ms != '0) ? OP_PPS : OP_MEAN;
        if (packet_total_r != '1) packet_total_r <= packet_total_r + COUNT_WIDTH'(1);
        byte_total_r <= byte_sum[BYTE_WIDTH] ? '1 : byte_sum[BYTE_WIDTH-1:0];
        case (in_chan.ip_proto) inside
          PROTO_TCP: begin
            if (tcp_total_r != '1) tcp_total_r <= tcp_total_r + COUNT_WIDTH'(1);
          end
          PROTO_UDP: begin
            if (udp_total_r != '1) udp_total_r <= udp_total_r + COUNT_WIDTH'(1);
          end
          PROTO_ICMP, PROTO_ICMP6: begin
            if (icmp_total_r != '1) icmp_total_r <= icmp_total_r + COUNT_WIDTH'(1);
          end
          default: begin
            if (other_total_r != '1) other_total_r <= other_total_r + COUNT_WIDTH'(1);
          end
        endcase
      end

      // Store each quotient as it completes and move to the next one.
      if (div_capture) begin
        case (op_r)
          OP_PPS: begin
            held_packet_rate_r <= div_sts.sat ? '1 : div_quotient[PPS_W-1:0];
            op_r               <= OP_BPS;
          end
          OP_BPS: begin
            held_bps_r <= div_sts.sat ? '1 : div_quotient[BPS_W-1:0];
            op_r       <= OP_MEAN;
          end
          default: begin
            held_mean_length_r <= div_sts.sat ? '1 : div_quotient[MEAN_W-1:0];
          end
        endcase
      end

      // Result valid: set on load, cleared when the transaction completes.
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers: event data, dividend and the result.
  always_ff @(posedge clk) begin
    if (in_accept) ms_r <= in_chan.elapsed_ms;
    if (prod_load) prod_r <= prod_nxt;
    if (out_load) begin
      out_pkt_count_r  <= clamp_cnt(packet_total_r);
      out_byte_count_r <= clamp_bytes(byte_total_r);
      out_tcp_count_r  <= clamp_cnt(tcp_total_r);
      out_udp_count_r  <= clamp_cnt(udp_total_r);
      out_icmp_count_r <= clamp_cnt(icmp_total_r);
      out_misc_count_r <= clamp_cnt(other_total_r);
      out_pps_r        <= held_packet_rate_r;
      out_bps_r        <= held_bps_r;
      out_mean_r       <= held_mean_length_r;
    end
  end

  assign out_chan.valid              = out_valid_r;
  assign out_chan.pkt_count          = out_pkt_count_r;
  assign out_chan.byte_count         = out_byte_count_r;
  assign out_chan.tcp_count          = out_tcp_count_r;
  assign out_chan.udp_count          = out_udp_count_r;
  assign out_chan.icmp_count         = out_icmp_count_r;
  assign out_chan.misc_count         = out_misc_count_r;
  assign out_chan.packets_per_second = out_pps_r;
  assign out_chan.bits_per_second    = out_bps_r;
  assign out_chan.mean_length        = out_mean_r;

`ifndef NO_ASSERTIONS
  logic [COUNT_WIDTH+1:0] class_sum;
  assign class_sum = (COUNT_WIDTH + 2)'(tcp_total_r) + (COUNT_WIDTH + 2)'(udp_total_r)
                   + (COUNT_WIDTH + 2)'(icmp_total_r) + (COUNT_WIDTH + 2)'(other_total_r);

  // Only one event is in work: after an accept the input is closed.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> !in_chan.ready)
    else $error("input accepted while an event is in work");

  // Until the packet total saturates, the protocol classes add up to it.
  a_class_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (packet_total_r != '1) |-> (class_sum == (COUNT_WIDTH + 2)'(packet_total_r)))
    else $error("protocol counts do not add up to the packet total");

  // The divider is never started while it is still busy.
  a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_sts.busy)
    else $error("divider started while busy");
`endif

endmodule
